### hdl/mmdo_pkg.sv
package mmdo_pkg;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_COMMAND   = 2'd1,
        OP_TOGGLE    = 2'd2,
        OP_FORCE_OFF = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_MIN_ON  = 2'd0,
        CFG_MAX_ON  = 2'd1,
        CFG_MIN_OFF = 2'd2,
        CFG_MAX_OFF = 2'd3
    } t_cfg_idx;

    localparam int unsigned CFG_WIDTH = 32;
    localparam logic [CFG_WIDTH-1:0] RESET_HOLD_MS = 32'd1000;

    typedef struct packed {
        t_op  operation;
        logic level_request;
    } t_in_word;

    typedef struct packed {
        logic level;
        logic forced_switch;
        logic command_blocked;
    } t_out_word;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] min_on_ms;
        logic [CFG_WIDTH-1:0] max_on_ms;
        logic [CFG_WIDTH-1:0] min_off_ms;
        logic [CFG_WIDTH-1:0] max_off_ms;
    } t_cfg;

endpackage

### hdl/mmdo_core.sv
module mmdo_core #(
    parameter int TIME_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  mmdo_pkg::t_in_word i_word,
    input  mmdo_pkg::t_cfg     i_cfg,
    output mmdo_pkg::t_out_word o_result
);
    import mmdo_pkg::*;

    localparam logic [63:0] TimeMax64 = 64'((65'd1 << TIME_WIDTH) - 65'd1);
    localparam logic [TIME_WIDTH-1:0] ResetHold =
        (TIME_WIDTH >= 10) ? TIME_WIDTH'(RESET_HOLD_MS) : '1;

    // clamp a register value to the counter range
    function automatic logic [TIME_WIDTH-1:0] sat_time(input logic [CFG_WIDTH-1:0] v);
        logic [63:0] v64;
        v64 = 64'(v);
        if (v64 > TimeMax64) begin
            return '1;
        end
        return TIME_WIDTH'(v64);
    endfunction

    logic                  r_level;
    logic [TIME_WIDTH-1:0] r_min_rem;
    logic [TIME_WIDTH-1:0] r_max_rem;
    logic                  r_armed;

    logic                  n_level;
    logic [TIME_WIDTH-1:0] n_min_rem;
    logic [TIME_WIDTH-1:0] n_max_rem;
    logic                  n_armed;

    logic                  want;
    logic                  take_en;
    logic                  take_lv;
    logic                  forced;
    logic                  blocked;
    logic [CFG_WIDTH-1:0]  ld_min;
    logic [CFG_WIDTH-1:0]  ld_max;

    assign ld_min = take_lv ? i_cfg.min_on_ms : i_cfg.min_off_ms;
    assign ld_max = take_lv ? i_cfg.max_on_ms : i_cfg.max_off_ms;

    always_comb begin
        want    = (i_word.operation == OP_COMMAND) ? i_word.level_request : ~r_level;
        take_en = 1'b0;
        take_lv = want;
        forced  = 1'b0;
        blocked = 1'b0;
        if (i_word.operation == OP_COMMAND || i_word.operation == OP_TOGGLE) begin
            if (r_min_rem != '0) begin
                blocked = 1'b1;
            end else if (want != r_level) begin
                take_en = 1'b1;
            end else if (r_armed && r_max_rem == '0) begin
                take_en = 1'b1;
                take_lv = ~r_level;
                forced  = 1'b1;
            end
        end
    end

    always_comb begin
        n_level   = r_level;
        n_min_rem = r_min_rem;
        n_max_rem = r_max_rem;
        n_armed   = r_armed;
        case (i_word.operation)
            OP_TICK: begin
                if (r_min_rem != '0) n_min_rem = r_min_rem - TIME_WIDTH'(1);
                if (r_max_rem != '0) n_max_rem = r_max_rem - TIME_WIDTH'(1);
            end
            OP_FORCE_OFF: begin
                n_level   = 1'b0;
                n_min_rem = sat_time(i_cfg.min_off_ms);
                n_max_rem = '0;
                n_armed   = 1'b0;
            end
            default: begin
                if (take_en) begin
                    n_level   = take_lv;
                    n_min_rem = sat_time(ld_min);
                    n_armed   = (ld_max != '0);
                    n_max_rem = (ld_max != '0) ? sat_time(ld_max) : '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= 1'b0;
            r_min_rem <= ResetHold;
            r_max_rem <= '0;
            r_armed   <= 1'b0;
        end else if (i_step) begin
            r_level   <= n_level;
            r_min_rem <= n_min_rem;
            r_max_rem <= n_max_rem;
            r_armed   <= n_armed;
        end
    end

    assign o_result.level           = n_level;
    assign o_result.forced_switch   = forced;
    assign o_result.command_blocked = blocked;

    a_tick_holds_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_word.operation == OP_TICK |=> r_level == $past(r_level))
        else $error("tick changed the output level");

    a_force_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_word.operation == OP_FORCE_OFF |=> !r_level && !r_armed)
        else $error("force off left the output on or the maximum timer armed");

    a_blocked_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && blocked |=> r_level == $past(r_level) && r_min_rem == $past(r_min_rem))
        else $error("blocked command altered state");

    a_forced_flips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && forced |=> r_level != $past(r_level))
        else $error("forced switch did not flip the output");

    a_unarmed_max_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_step) && !r_armed && $past(take_en) |-> r_max_rem == '0)
        else $error("disarmed maximum timer loaded non-zero");

endmodule

### hdl/min_max_dwell_output_unit.sv
// Dwell-limited digital output. One word is taken per clock cycle unless stalled, and its
// result word appears in the output register on the next cycle; the single output register
// with its valid flag sets the rate; a new word is accepted while a result waits as long as
// the consumer takes it in the same cycle. Tick words count the minimum and maximum dwell
// counters down, command and toggle words are ignored while the minimum dwell runs, an
// expired armed maximum dwell flips the output when the held level is commanded again, and
// force-off turns the output off at once. After reset the output is off with a 1000-tick
// hold. Counters are TIME_WIDTH bits and register values beyond that range saturate.
module min_max_dwell_output_unit #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  mmdo_pkg::t_in_word            i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output mmdo_pkg::t_out_word           o_out_word,
    input  logic                          i_cfg_we,
    input  mmdo_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [mmdo_pkg::CFG_WIDTH-1:0] i_cfg_data
);
    import mmdo_pkg::*;

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word result;
    logic      step;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign step       = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_ON:  r_cfg.min_on_ms  <= i_cfg_data;
                CFG_MAX_ON:  r_cfg.max_on_ms  <= i_cfg_data;
                CFG_MIN_OFF: r_cfg.min_off_ms <= i_cfg_data;
                CFG_MAX_OFF: r_cfg.max_off_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mmdo_core #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_word   (i_in_word),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("waiting result word was lost or changed");

    a_accept_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_out_valid)
        else $error("accepted word produced no result");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.forced_switch && o_out_word.command_blocked))
        else $error("forced and blocked both set");

endmodule
